[rtl/core/vffd_pkg.sv]
// Types, constants and tables shared by the V-formation follower drive
package vffd_pkg;

	localparam int CW = 28;
	localparam int ZW = 26;
	localparam int PW = 55;
	localparam int DIV_NW = 16;
	localparam int DIV_DW = 19;
	localparam int DIV_KW = 6;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 12;

	localparam logic signed [ZW-1:0] DEG90  = 26'sd2304000;
	localparam logic signed [ZW-1:0] DEG180 = 26'sd4608000;
	localparam logic signed [ZW-1:0] DEG360 = 26'sd9216000;
	localparam logic signed [17:0] INV_GAIN = 18'sd39797;
	localparam logic [20:0] TURN_RECIP = 21'd1342178;
	localparam logic [DIV_KW-1:0] BRAKE_STEPS = 6'd16;
	localparam logic [16:0] BRAKE_ONE = 17'd65536;
	localparam logic signed [16:0] WHEEL_LIM = 17'sd25600;

	localparam logic [CFG_IW-1:0] CFG_SPACING = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_DGAIN   = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_AGAIN   = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_FCAP    = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_TCAP    = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_ARRIVAL = 3'd5;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_ROW, OP_OFFSET, OP_ROT, OP_MUL_X, OP_TX, OP_MUL_Y, OP_TY,
		OP_VEC, OP_MUL_MAG, OP_DIST, OP_ERR, OP_MUL_TURN, OP_DIV_TURN, OP_TURN,
		OP_COS, OP_MUL_COS, OP_COSQ, OP_MUL_P1, OP_MUL_P2, OP_FWD, OP_DIV_BRAKE,
		OP_BRAKE, OP_MUL_BRK, OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic no_slot;
		logic row_more;
		logic arrived;
		logic cordic_done;
		logic div_done;
	} status_t;

	function automatic logic [20:0] atan_lut(input logic [3:0] i);
		logic [20:0] v;
		case (i)
			4'd0: v = 21'd1152000;
			4'd1: v = 21'd680065;
			4'd2: v = 21'd359328;
			4'd3: v = 21'd182400;
			4'd4: v = 21'd91554;
			4'd5: v = 21'd45822;
			4'd6: v = 21'd22916;
			4'd7: v = 21'd11459;
			4'd8: v = 21'd5730;
			4'd9: v = 21'd2865;
			4'd10: v = 21'd1432;
			4'd11: v = 21'd716;
			4'd12: v = 21'd358;
			4'd13: v = 21'd179;
			4'd14: v = 21'd90;
			default: v = 21'd45;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/vffd_cordic.sv]
// Shared CORDIC unit, rotation and vectoring, one iteration per cycle
module vffd_cordic
	import vffd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 rot,
	input  logic signed [CW-1:0] x0,
	input  logic signed [CW-1:0] y0,
	input  logic signed [ZW-1:0] z0,
	output logic                 done,
	output logic signed [CW-1:0] x,
	output logic signed [CW-1:0] y,
	output logic signed [ZW-1:0] z
);

	logic signed [CW-1:0] x_q, y_q, px, py, xs, ys;
	logic signed [ZW-1:0] z_q, pz, za, atn;
	logic [3:0] i_q;
	logic run_q, done_q, rot_q, zero_q, pos;

	always_comb begin
		px = x0;
		py = y0;
		za = z0;
		pz = z0;
		if (rot) begin
			if (z0 > DEG180) za = z0 - DEG360;
			else if (z0 < -DEG180) za = z0 + DEG360;
			pz = za;
			if (za > DEG90) begin
				px = -y0;
				py = x0;
				pz = za - DEG90;
			end else if (za < -DEG90) begin
				px = y0;
				py = -x0;
				pz = za + DEG90;
			end
		end else begin
			pz = '0;
			if (x0 < 0) begin
				if (y0 >= 0) begin
					px = y0;
					py = -x0;
					pz = DEG90;
				end else begin
					px = -y0;
					py = x0;
					pz = -DEG90;
				end
			end
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign atn = ZW'($signed({1'b0, atan_lut(i_q)}));
	assign pos = rot_q ? (z_q >= 0) : !(y_q > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q <= '0;
			end else if (run_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'd15) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= px;
			y_q <= py;
			z_q <= pz;
			rot_q <= rot;
			zero_q <= !rot && (x0 == 0) && (y0 == 0);
		end else if (run_q) begin
			if (pos) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atn;
			end
		end
	end

	assign done = done_q;
	assign x = zero_q ? '0 : x_q;
	assign y = zero_q ? '0 : y_q;
	assign z = zero_q ? '0 : z_q;

endmodule

[rtl/core/vffd_div.sv]
// Serial restoring divider, one quotient bit per cycle
module vffd_div
	import vffd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	input  logic [DIV_DW-1:0] rem0,
	input  logic [DIV_KW-1:0] cnt,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_DW-1:0] rem_q, den_q;
	logic [DIV_DW:0] tr, diff;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_KW-1:0] k_q;
	logic run_q, done_q, ge;

	assign tr = {rem_q, num_q[DIV_NW-1]};
	assign diff = tr - {1'b0, den_q};
	assign ge = tr >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			k_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				k_q <= cnt;
			end else if (run_q) begin
				k_q <= k_q - 1'b1;
				if (k_q == DIV_KW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem0;
			num_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : tr[DIV_DW-1:0];
			num_q <= {num_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = num_q;

endmodule

[rtl/core/vffd_datapath.sv]
// Datapath: settings, operand registers, shared multiplier, CORDIC and divider
module vffd_datapath
	import vffd_pkg::*;
#(
	parameter int MAX_SLOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            st,
	input  logic               cfg_valid,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]  cfg_data,
	input  logic signed [15:0] leader_x,
	input  logic signed [15:0] leader_y,
	input  logic signed [15:0] leader_heading,
	input  logic signed [15:0] follower_x,
	input  logic signed [15:0] follower_y,
	input  logic signed [15:0] follower_heading,
	input  logic [5:0]         slot_index,
	input  logic               has_slot,
	output logic signed [7:0]  left_drive,
	output logic signed [7:0]  right_drive,
	output logic               arrived
);

	function automatic logic signed [7:0] wheel(input logic signed [16:0] s);
		logic signed [16:0] c;
		logic [16:0] m;
		if (s > WHEEL_LIM) c = WHEEL_LIM;
		else if (s < -WHEEL_LIM) c = -WHEEL_LIM;
		else c = s;
		m = c[16] ? 17'(-c) : 17'(c);
		m = m >> 8;
		return c[16] ? -$signed({1'b0, m[6:0]}) : $signed({1'b0, m[6:0]});
	endfunction

	logic [11:0] spacing_q;
	logic [9:0] dgain_q, again_q, arr_mm_q;
	logic [10:0] fcap_q;
	logic [6:0] tcap_q;

	logic signed [15:0] lx_q, ly_q, lh_q, fx_q, fy_q, fh_q, tx_q, ty_q, turn_q, tclamp;
	logic [5:0] idx_q, start_q;
	logic has_q, neg_q, full_q, no_slot;
	logic [3:0] row_q, col;
	logic [15:0] rs;
	logic signed [5:0] cs;
	logic signed [18:0] oym;
	logic signed [CW-1:0] ox_q, oy_q, cx0, cy0, cx, cy;
	logic signed [ZW-1:0] cz0, cz, err_q;
	logic signed [ZW:0] e_raw, e_wr;
	logic signed [16:0] dx;
	logic crot, cstart, cdone;
	logic signed [17:0] mul_a, cosq_q;
	logic signed [36:0] mul_b;
	logic signed [PW-1:0] mul_p, prod_q, r24, r16, tsum, pabs, f24;
	logic signed [15:0] tbase;
	logic [24:0] dist_q, dd_q, dd;
	logic [17:0] arr;
	logic [18:0] arr2;
	logic dstart, ddone;
	logic [DIV_NW-1:0] dnum, dquo;
	logic [DIV_DW-1:0] dden, drem0;
	logic [DIV_KW-1:0] dcnt;
	logic [19:0] tsat;
	logic [40:0] tprod;
	logic [15:0] tq_q;
	logic [14:0] fwd_q, cap16, tlim, tmag, fo;
	logic [16:0] brake_q;
	logic signed [7:0] left_q, right_q;
	logic arrived_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= 12'd250;
			dgain_q <= 10'd102;
			again_q <= 10'd115;
			fcap_q <= 11'd579;
			tcap_q <= 7'd24;
			arr_mm_q <= 10'd55;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SPACING: spacing_q <= cfg_data;
				CFG_DGAIN: dgain_q <= cfg_data[9:0];
				CFG_AGAIN: again_q <= cfg_data[9:0];
				CFG_FCAP: fcap_q <= cfg_data[10:0];
				CFG_TCAP: tcap_q <= cfg_data[6:0];
				CFG_ARRIVAL: arr_mm_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign no_slot = !has_q || ({3'b0, idx_q} >= 9'(MAX_SLOTS));
	assign col = 4'(idx_q - start_q);
	assign rs = {12'b0, row_q} * {4'b0, spacing_q};
	assign cs = $signed({1'b0, col, 1'b0}) - $signed({2'b0, row_q});
	assign oym = 19'(cs) * 19'($signed({1'b0, spacing_q}));

	assign dx = 17'(tx_q) - 17'(fx_q);
	assign arr = {arr_mm_q, 8'b0};
	assign arr2 = {arr_mm_q, 9'b0};
	assign dd = dist_q - {7'b0, arr};

	always_comb begin
		crot = 1'b1;
		cx0 = ox_q;
		cy0 = oy_q;
		cz0 = ZW'($signed({lh_q, 8'b0}));
		cstart = 1'b0;
		case (cmd.op)
			OP_ROT: cstart = 1'b1;
			OP_VEC: begin
				cstart = 1'b1;
				crot = 1'b0;
				cx0 = CW'($signed({dx, 8'b0}));
				cy0 = CW'($signed({17'(ty_q) - 17'(fy_q), 8'b0}));
				cz0 = '0;
			end
			OP_COS: begin
				cstart = 1'b1;
				cx0 = CW'(32'sd16777216);
				cy0 = '0;
				cz0 = err_q;
			end
			default: ;
		endcase
	end

	vffd_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart), .rot(crot),
		.x0(cx0), .y0(cy0), .z0(cz0), .done(cdone), .x(cx), .y(cy), .z(cz)
	);

	assign pabs = prod_q[PW-1] ? -prod_q : prod_q;

	// turn magnitude: floor(|p| / 25600) as floor((|p| >> 10) / 25) by reciprocal
	assign tsat = (pabs[PW-1:30] != '0) ? '1 : pabs[29:10];
	assign tprod = tsat * TURN_RECIP;

	assign dstart = (cmd.op == OP_DIV_BRAKE);
	assign dnum = '0;
	assign dden = arr2;
	assign drem0 = dd_q[DIV_DW-1:0];
	assign dcnt = BRAKE_STEPS;

	vffd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.rem0(drem0), .cnt(dcnt), .done(ddone), .quo(dquo)
	);

	always_comb begin
		mul_a = INV_GAIN;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_X, OP_MUL_MAG, OP_MUL_COS: mul_b = 37'(cx);
			OP_MUL_Y: mul_b = 37'(cy);
			OP_MUL_TURN: begin
				mul_a = $signed({8'b0, again_q});
				mul_b = 37'(err_q);
			end
			OP_MUL_P1: begin
				mul_a = $signed({8'b0, dgain_q});
				mul_b = $signed({12'b0, dist_q});
			end
			OP_MUL_P2: begin
				mul_a = cosq_q;
				mul_b = prod_q[36:0];
			end
			OP_MUL_BRK: begin
				mul_a = $signed({1'b0, brake_q});
				mul_b = $signed({22'b0, fwd_q});
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign r24 = (prod_q + PW'(32'sd8388608)) >>> 24;
	assign r16 = (prod_q + PW'(32'sd32768)) >>> 16;
	assign tbase = (cmd.op == OP_TY) ? ly_q : lx_q;
	assign tsum = r24 + PW'(tbase);
	assign tclamp = (tsum > PW'(32'sd32767)) ? 16'sh7fff :
		(tsum < PW'(-32'sd32768)) ? 16'sh8000 : tsum[15:0];
	assign e_raw = (ZW+1)'(cz) - (ZW+1)'($signed({fh_q, 8'b0}));
	assign e_wr = (e_raw > (ZW+1)'(DEG180)) ? e_raw - (ZW+1)'(DEG360) :
		(e_raw < -(ZW+1)'(DEG180)) ? e_raw + (ZW+1)'(DEG360) : e_raw;
	assign tlim = {tcap_q, 8'b0};
	assign tmag = (tq_q > {1'b0, tlim}) ? tlim : tq_q[14:0];
	assign f24 = prod_q >>> 24;
	assign cap16 = {fcap_q, 4'b0};
	assign fo = prod_q[30:16];

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				lx_q <= leader_x;
				ly_q <= leader_y;
				lh_q <= leader_heading;
				fx_q <= follower_x;
				fy_q <= follower_y;
				fh_q <= follower_heading;
				idx_q <= slot_index;
				has_q <= has_slot;
				row_q <= 4'd1;
				start_q <= '0;
			end
			OP_ROW: begin
				start_q <= start_q + {2'b0, row_q} + 6'd1;
				row_q <= row_q + 4'd1;
			end
			OP_OFFSET: begin
				ox_q <= -$signed({4'b0, rs, 8'b0});
				oy_q <= CW'($signed({oym, 8'b0}));
			end
			OP_MUL_X, OP_MUL_Y, OP_MUL_MAG, OP_MUL_TURN, OP_MUL_COS, OP_MUL_P1,
			OP_MUL_P2, OP_MUL_BRK: prod_q <= mul_p;
			OP_TX: tx_q <= tclamp;
			OP_TY: ty_q <= tclamp;
			OP_DIST: dist_q <= r16[24:0];
			OP_ERR: err_q <= e_wr[ZW-1:0];
			OP_DIV_TURN: begin
				neg_q <= prod_q[PW-1];
				tq_q <= tprod[40:25];
			end
			OP_TURN: turn_q <= neg_q ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
			OP_COSQ: cosq_q <= r24[17:0];
			OP_FWD: begin
				if (prod_q <= 0) fwd_q <= '0;
				else if ((f24[PW-1:15] != 0) || (f24[14:0] > cap16)) fwd_q <= cap16;
				else fwd_q <= f24[14:0];
				dd_q <= dd;
				full_q <= (arr_mm_q == 10'd0) || (dd >= {6'b0, arr2});
			end
			OP_BRAKE: brake_q <= full_q ? BRAKE_ONE : {1'b0, dquo[15:0]};
			OP_OUT: begin
				if (no_slot) begin
					left_q <= '0;
					right_q <= '0;
					arrived_q <= 1'b0;
				end else if (st.arrived) begin
					left_q <= '0;
					right_q <= '0;
					arrived_q <= 1'b1;
				end else begin
					left_q <= wheel($signed({2'b0, fo}) + 17'(turn_q));
					right_q <= wheel($signed({2'b0, fo}) - 17'(turn_q));
					arrived_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		st.no_slot = no_slot;
		st.row_more = ({1'b0, start_q} + {3'b0, row_q} + 7'd1) <= {1'b0, idx_q};
		st.arrived = dist_q < {7'b0, arr};
		st.cordic_done = cdone;
		st.div_done = ddone;
	end

	assign left_drive = left_q;
	assign right_drive = right_q;
	assign arrived = arrived_q;

endmodule

[rtl/core/vffd_ctrl.sv]
// Controller: sequences the datapath through one item
module vffd_ctrl
	import vffd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t st,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	typedef enum logic [27:0] {
		S_IDLE   = 28'd1 << 0,
		S_ROW    = 28'd1 << 1,
		S_ROT    = 28'd1 << 2,
		S_ROT_W  = 28'd1 << 3,
		S_MULX   = 28'd1 << 4,
		S_TX     = 28'd1 << 5,
		S_MULY   = 28'd1 << 6,
		S_TY     = 28'd1 << 7,
		S_VEC    = 28'd1 << 8,
		S_VEC_W  = 28'd1 << 9,
		S_MULM   = 28'd1 << 10,
		S_DIST   = 28'd1 << 11,
		S_CHK    = 28'd1 << 12,
		S_MULT   = 28'd1 << 13,
		S_DIVT   = 28'd1 << 14,
		S_TURN   = 28'd1 << 15,
		S_COS    = 28'd1 << 16,
		S_COS_W  = 28'd1 << 17,
		S_MULC   = 28'd1 << 18,
		S_CQ     = 28'd1 << 19,
		S_MULP   = 28'd1 << 20,
		S_MULF   = 28'd1 << 21,
		S_FWD    = 28'd1 << 22,
		S_DIVB   = 28'd1 << 23,
		S_DIVB_W = 28'd1 << 24,
		S_BRK    = 28'd1 << 25,
		S_MULB   = 28'd1 << 26,
		S_OUT    = 28'd1 << 27
	} state_t;

	state_t state_q, state_d;
	logic done_q;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NOP;
		case (state_q)
			S_IDLE: if (start) begin
				cmd.op = OP_LOAD;
				state_d = S_ROW;
			end
			S_ROW: if (st.no_slot) begin
				state_d = S_OUT;
			end else if (st.row_more) begin
				cmd.op = OP_ROW;
			end else begin
				cmd.op = OP_OFFSET;
				state_d = S_ROT;
			end
			S_ROT: begin
				cmd.op = OP_ROT;
				state_d = S_ROT_W;
			end
			S_ROT_W: if (st.cordic_done) state_d = S_MULX;
			S_MULX: begin
				cmd.op = OP_MUL_X;
				state_d = S_TX;
			end
			S_TX: begin
				cmd.op = OP_TX;
				state_d = S_MULY;
			end
			S_MULY: begin
				cmd.op = OP_MUL_Y;
				state_d = S_TY;
			end
			S_TY: begin
				cmd.op = OP_TY;
				state_d = S_VEC;
			end
			S_VEC: begin
				cmd.op = OP_VEC;
				state_d = S_VEC_W;
			end
			S_VEC_W: if (st.cordic_done) state_d = S_MULM;
			S_MULM: begin
				cmd.op = OP_MUL_MAG;
				state_d = S_DIST;
			end
			S_DIST: begin
				cmd.op = OP_DIST;
				state_d = S_CHK;
			end
			S_CHK: if (st.arrived) begin
				state_d = S_OUT;
			end else begin
				cmd.op = OP_ERR;
				state_d = S_MULT;
			end
			S_MULT: begin
				cmd.op = OP_MUL_TURN;
				state_d = S_DIVT;
			end
			S_DIVT: begin
				cmd.op = OP_DIV_TURN;
				state_d = S_TURN;
			end
			S_TURN: begin
				cmd.op = OP_TURN;
				state_d = S_COS;
			end
			S_COS: begin
				cmd.op = OP_COS;
				state_d = S_COS_W;
			end
			S_COS_W: if (st.cordic_done) state_d = S_MULC;
			S_MULC: begin
				cmd.op = OP_MUL_COS;
				state_d = S_CQ;
			end
			S_CQ: begin
				cmd.op = OP_COSQ;
				state_d = S_MULP;
			end
			S_MULP: begin
				cmd.op = OP_MUL_P1;
				state_d = S_MULF;
			end
			S_MULF: begin
				cmd.op = OP_MUL_P2;
				state_d = S_FWD;
			end
			S_FWD: begin
				cmd.op = OP_FWD;
				state_d = S_DIVB;
			end
			S_DIVB: begin
				cmd.op = OP_DIV_BRAKE;
				state_d = S_DIVB_W;
			end
			S_DIVB_W: if (st.div_done) state_d = S_BRK;
			S_BRK: begin
				cmd.op = OP_BRAKE;
				state_d = S_MULB;
			end
			S_MULB: begin
				cmd.op = OP_MUL_BRK;
				state_d = S_OUT;
			end
			S_OUT: begin
				cmd.op = OP_OUT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == S_OUT);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_OUT)) else $error("result strobe without output step");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_ROW)) else $error("accepted item not started");

endmodule

[rtl/core/v_formation_follower_drive.sv]
// Top level of the V-formation follower drive
// An item is taken when start is high and busy is low. The result appears on
// left_drive, right_drive and arrived for one cycle with done high, and must be
// captured then; the receiver cannot stall. An item with no valid slot goes
// straight to the output step; for the others the time grows with the formation
// row (1 to 10 for 64 slots). An item that has arrived stops after the distance
// check; a full item makes three passes through the shared 16-iteration CORDIC
// and one 16-step serial division for the braking ramp.
// busy is high from the accepting edge until done rises; a new item can be
// taken in the cycle of done.
module v_formation_follower_drive
	import vffd_pkg::*;
#(
	parameter int MAX_SLOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] leader_x,
	input  logic signed [15:0] leader_y,
	input  logic signed [15:0] leader_heading,
	input  logic signed [15:0] follower_x,
	input  logic signed [15:0] follower_y,
	input  logic signed [15:0] follower_heading,
	input  logic [5:0]         slot_index,
	input  logic               has_slot,
	output logic               done,
	output logic signed [7:0]  left_drive,
	output logic signed [7:0]  right_drive,
	output logic               arrived,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]  cfg_data
);

	cmd_t cmd;
	status_t st;

	assign cfg_ready = 1'b1;

	vffd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .st(st), .cmd(cmd),
		.busy(busy), .done(done)
	);

	vffd_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.leader_x(leader_x), .leader_y(leader_y), .leader_heading(leader_heading),
		.follower_x(follower_x), .follower_y(follower_y),
		.follower_heading(follower_heading), .slot_index(slot_index), .has_slot(has_slot),
		.left_drive(left_drive), .right_drive(right_drive), .arrived(arrived)
	);

endmodule
